// ===== rtl/ole_pkg.sv =====
// Shared types and constants for the ordered list engine.
// Used by ordered_list_engine_unit; no dependencies.
package ole_pkg;

  localparam int CAPACITY = 16;
  localparam int AW       = $clog2(CAPACITY);
  localparam int LW       = $clog2(CAPACITY + 1);
  localparam int POS_W    = 5;
  localparam int CW       = (LW > POS_W) ? LW : POS_W;
  localparam int VAL_W    = 32;

  localparam logic [2:0] CMD_APPEND  = 3'd0;
  localparam logic [2:0] CMD_INSERT  = 3'd1;
  localparam logic [2:0] CMD_DEL_VAL = 3'd2;
  localparam logic [2:0] CMD_DEL_POS = 3'd3;
  localparam logic [2:0] CMD_DUMP    = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [2:0]              command;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [POS_W-1:0]        item_position;
    logic signed [VAL_W-1:0] item_value;
    logic                    last;
  } out_word_t;

endpackage

// ===== rtl/ordered_list_engine_unit.sv =====
// Ordered list engine: a list of signed 32-bit values kept in list order in a RAM.
// Depends on ole_pkg and ole_ram.
//
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd) takes one command word: append,
//   insert at a 1-based position, delete by value, delete by position, dump.
//   rsp channel (rsp_valid/rsp_ready/rsp) returns result words. Append,
//   insert and the deletes return one status word; dump returns one word per
//   element (position, value, last on the final one), or one empty status.
//   Commands five to seven are taken and dropped without a result.
// Timing:
//   cmd_ready is high only while the sequencer is idle. All list work goes
//   through the single RAM port pair; the shifts and the delete-by-value scan
//   move one entry per cycle, and a dump reads and then emits each element in
//   turn. An append writes at the end; an insert first shifts the entries from
//   its position up by one place; a delete shifts the later entries down. A
//   full-list command or an out-of-range delete by position goes straight to
//   its status word. The sequencer is idle again, ready for the next command,
//   in the cycle after the final word is loaded.
//   The result sits in an output register, so a new command may be taken
//   while the last result waits; a stalled receiver holds the sequencer
//   only when it has a further word to deliver.
// Reset: synchronous, clears the list length and the sequencer; the RAM is
//   not cleared (entries beyond the length are never used).
module ordered_list_engine_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  ole_pkg::in_word_t   cmd,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output ole_pkg::out_word_t  rsp
);

  typedef enum logic [2:0] {
    S_IDLE, S_SHIFT_UP, S_INS_WR, S_SCAN, S_SHIFT_DN, S_STATUS, S_DUMP_RD, S_DUMP_EMIT
  } state_t;

  state_t                       state;
  ole_pkg::in_word_t            req;
  logic [ole_pkg::LW-1:0]       len;
  logic [ole_pkg::LW-1:0]       idx;
  logic [ole_pkg::LW-1:0]       tgt;
  logic [ole_pkg::AW-1:0]       ptr;
  logic                         pend;
  logic [1:0]                   st;
  logic                         out_valid;
  ole_pkg::out_word_t           out_word;

  logic                         ram_we;
  logic [ole_pkg::AW-1:0]       ram_waddr;
  logic [ole_pkg::VAL_W-1:0]    ram_wdata;
  logic [ole_pkg::AW-1:0]       ram_raddr;
  logic [ole_pkg::VAL_W-1:0]    ram_rdata;

  logic [ole_pkg::LW-1:0]       idx_p1;
  logic [ole_pkg::LW-1:0]       idx_m1;
  logic [ole_pkg::CW-1:0]       pos_w;
  logic [ole_pkg::CW-1:0]       len_w;
  logic                         pos_ok;
  logic                         full;
  logic                         out_free;
  logic                         emit;

  assign idx_p1   = idx + ole_pkg::LW'(1);
  assign idx_m1   = idx - ole_pkg::LW'(1);
  assign pos_w    = ole_pkg::CW'(cmd.position);
  assign len_w    = ole_pkg::CW'(len);
  assign pos_ok   = (cmd.position != '0) && (pos_w <= len_w);
  assign full     = (len == ole_pkg::LW'(ole_pkg::CAPACITY));
  assign out_free = !out_valid || rsp_ready;
  assign emit     = out_free && ((state == S_STATUS) || (state == S_DUMP_EMIT));

  assign cmd_ready = (state == S_IDLE);
  assign rsp_valid = out_valid;
  assign rsp       = out_word;

  always_comb begin
    ram_raddr = idx[ole_pkg::AW-1:0];
    ram_we    = 1'b0;
    ram_waddr = ptr;
    ram_wdata = ram_rdata;
    unique case (state)
      S_SHIFT_UP: begin
        ram_raddr = idx_m1[ole_pkg::AW-1:0];
        ram_we    = pend;
      end
      S_SHIFT_DN: begin
        ram_raddr = idx_p1[ole_pkg::AW-1:0];
        ram_we    = pend;
      end
      S_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = tgt[ole_pkg::AW-1:0];
        ram_wdata = req.value;
      end
      default: begin
      end
    endcase
  end

  ole_ram #(
    .WIDTH(ole_pkg::VAL_W),
    .DEPTH(ole_pkg::CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      len       <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // drop the word once taken, unless a new one loads in its place
      if (rsp_valid && rsp_ready && !emit) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          pend <= 1'b0;
          if (cmd_valid) begin
            req <= cmd;
            unique case (cmd.command) inside
              ole_pkg::CMD_APPEND, ole_pkg::CMD_INSERT: begin
                if (full) begin
                  st    <= ole_pkg::ST_FULL;
                  state <= S_STATUS;
                end else begin
                  if (cmd.command == ole_pkg::CMD_INSERT && pos_ok) begin
                    tgt <= ole_pkg::LW'(pos_w - ole_pkg::CW'(1));
                  end else begin
                    tgt <= len;
                  end
                  idx   <= len;
                  state <= S_SHIFT_UP;
                end
              end
              ole_pkg::CMD_DEL_VAL: begin
                idx   <= '0;
                state <= S_SCAN;
              end
              ole_pkg::CMD_DEL_POS: begin
                if (pos_ok) begin
                  idx   <= ole_pkg::LW'(pos_w - ole_pkg::CW'(1));
                  state <= S_SHIFT_DN;
                end else begin
                  st    <= ole_pkg::ST_NOT_FOUND;
                  state <= S_STATUS;
                end
              end
              ole_pkg::CMD_DUMP: begin
                idx <= '0;
                if (len == '0) begin
                  st    <= ole_pkg::ST_EMPTY;
                  state <= S_STATUS;
                end else begin
                  state <= S_DUMP_RD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        // read entry idx-1, write it one place on in the next cycle
        S_SHIFT_UP: begin
          if (idx != tgt) begin
            pend <= 1'b1;
            ptr  <= idx[ole_pkg::AW-1:0];
            idx  <= idx_m1;
          end else begin
            pend  <= 1'b0;
            state <= S_INS_WR;
          end
        end
        S_INS_WR: begin
          len   <= len + ole_pkg::LW'(1);
          st    <= ole_pkg::ST_OK;
          state <= S_STATUS;
        end
        // reads run one ahead of the compare
        S_SCAN: begin
          if (pend && ram_rdata == req.value) begin
            pend  <= 1'b0;
            idx   <= ole_pkg::LW'(ptr);
            state <= S_SHIFT_DN;
          end else if (idx < len) begin
            pend <= 1'b1;
            ptr  <= idx[ole_pkg::AW-1:0];
            idx  <= idx_p1;
          end else if (pend) begin
            pend <= 1'b0;
          end else begin
            st    <= ole_pkg::ST_NOT_FOUND;
            state <= S_STATUS;
          end
        end
        // read entry idx+1, write it one place back in the next cycle
        S_SHIFT_DN: begin
          if (idx_p1 < len) begin
            pend <= 1'b1;
            ptr  <= idx[ole_pkg::AW-1:0];
            idx  <= idx_p1;
          end else begin
            pend  <= 1'b0;
            len   <= len - ole_pkg::LW'(1);
            st    <= ole_pkg::ST_OK;
            state <= S_STATUS;
          end
        end
        S_STATUS: begin
          if (out_free) begin
            out_valid              <= 1'b1;
            out_word.status        <= st;
            out_word.item_position <= '0;
            out_word.item_value    <= '0;
            out_word.last          <= 1'b1;
            state                  <= S_IDLE;
          end
        end
        S_DUMP_RD: begin
          state <= S_DUMP_EMIT;
        end
        S_DUMP_EMIT: begin
          if (out_free) begin
            out_valid              <= 1'b1;
            out_word.status        <= ole_pkg::ST_OK;
            out_word.item_position <= ole_pkg::POS_W'(ole_pkg::CW'(idx_p1));
            out_word.item_value    <= ram_rdata;
            out_word.last          <= (idx_p1 == len);
            idx                    <= idx_p1;
            state                  <= (idx_p1 == len) ? S_IDLE : S_DUMP_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= ole_pkg::LW'(ole_pkg::CAPACITY))
    else $error("list length above capacity");

  a_len_step: assert property (@(posedge clk) disable iff (rst)
    !$stable(len) |-> (len == $past(len) + ole_pkg::LW'(1)) ||
                      (len == $past(len) - ole_pkg::LW'(1)) || $past(rst))
    else $error("list length moved by more than one");

  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !ram_we)
    else $error("RAM written while idle");

  a_dump_pos: assert property (@(posedge clk) disable iff (rst)
    (state == S_DUMP_EMIT) |-> (idx < len))
    else $error("dump index past list end");

endmodule

// ===== rtl/ole_ram.sv =====
// Generic RAM: one write port, one read port with registered read data.
// No dependencies.
module ole_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 16,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sim/tb_top.sv =====
// Testbench for ordered_list_engine_unit: drives command words, predicts each result word
// from its own copy of the list, and checks every result word in order. Needs ole_pkg.
`timescale 1ns / 1ps

module tb_top;

  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
  localparam int         CYCLE_LIMIT   = 400000;
  localparam int         SETTLE_CYCLES = 2 * ole_pkg::CAPACITY + 8;
  localparam int         WORDS_PER_PHASE = 70;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cmd_valid;
  logic               cmd_ready;
  ole_pkg::in_word_t  cmd;
  logic               rsp_valid;
  logic               rsp_ready = 1'b0;
  ole_pkg::out_word_t rsp;

  // list as the engine should hold it
  logic signed [ole_pkg::VAL_W-1:0] list_vals [ole_pkg::CAPACITY];
  int                               list_len;
  ole_pkg::out_word_t               expected_rsp [$];

  int error_count = 0;
  int cycle_count = 0;
  int send_idle_pct;
  int recv_idle_pct;

  ordered_list_engine_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic predict_list_op(input ole_pkg::in_word_t w);
    ole_pkg::out_word_t r;
    int                 slot;
    int                 hit;
    r = '0;
    r.last = 1'b1;
    case (w.command) inside
      ole_pkg::CMD_APPEND, ole_pkg::CMD_INSERT: begin
        if (list_len >= ole_pkg::CAPACITY) begin
          r.status = ole_pkg::ST_FULL;
        end else begin
          slot = list_len;
          if (w.command == ole_pkg::CMD_INSERT && w.position >= 1 &&
              w.position <= list_len) begin
            slot = w.position - 1;
          end
          for (int i = list_len; i > slot; i--) list_vals[i] = list_vals[i-1];
          list_vals[slot] = w.value;
          list_len++;
          r.status = ole_pkg::ST_OK;
        end
        expected_rsp.push_back(r);
      end
      ole_pkg::CMD_DEL_VAL, ole_pkg::CMD_DEL_POS: begin
        hit = -1;
        if (w.command == ole_pkg::CMD_DEL_VAL) begin
          for (int i = list_len - 1; i >= 0; i--) begin
            if (list_vals[i] == w.value) hit = i;
          end
        end else if (w.position >= 1 && w.position <= list_len) begin
          hit = w.position - 1;
        end
        if (hit < 0) begin
          r.status = ole_pkg::ST_NOT_FOUND;
        end else begin
          for (int i = hit; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
          list_len--;
          r.status = ole_pkg::ST_OK;
        end
        expected_rsp.push_back(r);
      end
      ole_pkg::CMD_DUMP: begin
        if (list_len == 0) begin
          r.status = ole_pkg::ST_EMPTY;
          expected_rsp.push_back(r);
        end else begin
          for (int i = 0; i < list_len; i++) begin
            r.status        = ole_pkg::ST_OK;
            r.item_position = ole_pkg::POS_W'(i + 1);
            r.item_value    = list_vals[i];
            r.last          = (i + 1 == list_len);
            expected_rsp.push_back(r);
          end
        end
      end
      default: ;  // unused codes are dropped by the engine
    endcase
  endtask

  always @(posedge clk) begin : rsp_check
    ole_pkg::out_word_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_rsp.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got %p", $time, rsp);
        error_count++;
      end else begin
        want = expected_rsp.pop_front();
        if (rsp.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, rsp.status);
          error_count++;
        end
        if (rsp.item_position !== want.item_position) begin
          $display("%0t: item_position expected %0d got %0d",
                   $time, want.item_position, rsp.item_position);
          error_count++;
        end
        if (rsp.item_value !== want.item_value) begin
          $display("%0t: item_value expected %0d got %0d",
                   $time, want.item_value, rsp.item_value);
          error_count++;
        end
        if (rsp.last !== want.last) begin
          $display("%0t: last expected %0b got %0b", $time, want.last, rsp.last);
          error_count++;
        end
      end
    end
  end

  // Drive one command word; returns at the edge that takes it, valid still high.
  task automatic send_word(input logic [2:0] code,
                           input logic [ole_pkg::POS_W-1:0] pos,
                           input logic signed [ole_pkg::VAL_W-1:0] val);
    ole_pkg::in_word_t w;
    w.command  = code;
    w.position = pos;
    w.value    = val;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= w;
    do @(posedge clk); while (!cmd_ready);
    predict_list_op(w);
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic set_idle(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  function automatic logic signed [ole_pkg::VAL_W-1:0] random_value();
    case ($urandom_range(0, 3))
      0:       return int'($urandom_range(0, 7)) - 4;  // small pool, many duplicates
      1:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_empty_list();
    send_word(ole_pkg::CMD_DUMP, 5'd0, 32'sd0);
    send_word(ole_pkg::CMD_DEL_VAL, 5'd0, 32'sh80000000);
    send_word(ole_pkg::CMD_DEL_POS, 5'd1, 32'sd0);
    send_word(3'd6, 5'd31, 32'shffffffff);
  endtask

  task automatic test_fill_to_capacity();
    send_word(ole_pkg::CMD_APPEND, 5'd0, 32'sh80000000);
    send_word(ole_pkg::CMD_INSERT, 5'd1, 32'sh7fffffff);   // new head
    send_word(ole_pkg::CMD_INSERT, 5'd0, 32'sd0);          // position zero appends
    send_word(ole_pkg::CMD_INSERT, 5'd31, -32'sd1);        // past the end appends
    send_word(ole_pkg::CMD_INSERT, 5'd2, 32'sh55555555);
    send_word(ole_pkg::CMD_INSERT, 5'd5, 32'sd0);          // duplicate value
    send_word(ole_pkg::CMD_APPEND, 5'd31, 32'shaaaaaaaa);
    for (int i = 1; i <= 9; i++) send_word(ole_pkg::CMD_APPEND, 5'd0, i);
    send_word(ole_pkg::CMD_APPEND, 5'd0, 32'sd77);
    send_word(ole_pkg::CMD_INSERT, 5'd3, 32'sd78);
    send_word(ole_pkg::CMD_DUMP, 5'd0, 32'sd0);
  endtask

  task automatic test_delete_cases();
    send_word(ole_pkg::CMD_DEL_VAL, 5'd0, 32'sd0);         // first of two equal entries
    send_word(ole_pkg::CMD_DEL_POS, 5'd15, 32'sd0);        // tail
    send_word(ole_pkg::CMD_DEL_POS, 5'd1, 32'sd0);         // head
    send_word(ole_pkg::CMD_DEL_POS, 5'd0, 32'sd0);
    send_word(ole_pkg::CMD_DEL_VAL, 5'd0, 32'sd12345);
    send_word(ole_pkg::CMD_DUMP, 5'd0, 32'sd0);
  endtask

  task automatic test_random_mix(input int n_words);
    int                               done_words;
    int                               pick;
    logic [ole_pkg::POS_W-1:0]        pos;
    logic signed [ole_pkg::VAL_W-1:0] val;
    done_words = 0;
    while (done_words < n_words) begin
      pick = $urandom_range(0, 99);
      pos  = ole_pkg::POS_W'($urandom_range(0, 31));
      val  = random_value();
      if (pick < 25) begin
        send_word(ole_pkg::CMD_APPEND, pos, val);
      end else if (pick < 45) begin
        if ($urandom_range(0, 3) != 0) pos = ole_pkg::POS_W'($urandom_range(1, list_len + 1));
        send_word(ole_pkg::CMD_INSERT, pos, val);
      end else if (pick < 62) begin
        if (list_len > 0 && $urandom_range(0, 3) != 0) begin
          val = list_vals[$urandom_range(0, list_len - 1)];
        end
        send_word(ole_pkg::CMD_DEL_VAL, pos, val);
      end else if (pick < 78) begin
        if (list_len > 0 && $urandom_range(0, 3) != 0) begin
          pos = ole_pkg::POS_W'($urandom_range(1, list_len));
        end
        send_word(ole_pkg::CMD_DEL_POS, pos, val);
      end else if (pick < 92) begin
        send_word(ole_pkg::CMD_DUMP, pos, val);
      end else begin
        send_word(3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)), pos, val);
        continue;
      end
      done_words++;
    end
  endtask

  initial begin
    cmd_valid   = 1'b0;
    cmd         = '0;
    list_len    = 0;
    set_idle(31, 76);
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    test_empty_list();
    test_fill_to_capacity();
    wait_all_results();
    test_delete_cases();
    test_random_mix(WORDS_PER_PHASE);
    wait_all_results();

    set_idle(76, 31);
    test_random_mix(WORDS_PER_PHASE);
    wait_all_results();

    set_idle(0, 0);
    test_random_mix(WORDS_PER_PHASE);
    wait_all_results();

    // let a trailing dropped command or a stray word show up
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_rsp.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
